// File: rtl/bdws_pkg.sv
`timescale 1ns / 1ps

package bdws_pkg;

  localparam int WindowBlocksDef = 8;
  localparam logic [11:0] BlockBytes = 12'd2048;
  localparam logic [15:0] TimeoutReset = 16'd1000;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDownloadEnabled = 2'd0,
    CfgPureMode        = 2'd1,
    CfgTimeout         = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdRead  = 2'd1,
    CmdAck   = 2'd2,
    CmdSend  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindRead  = 2'd0,
    KindBlock = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ErrArchive      = 2'd0,
    ErrDisabledPure = 2'd1,
    ErrDisabled     = 2'd2,
    ErrNotFound     = 2'd3
  } err_e;

  typedef struct packed {
    logic        download_enabled;
    logic        pure_mode;
    logic [15:0] timeout;
  } cfg_t;

  // A classified request as it waits in the queue between front and back.
  typedef struct packed {
    cmd_e        cmd;
    logic        refused;
    err_e        err;
    logic [30:0] file_size;
    logic        len_neg;
    logic [11:0] len;
    logic [15:0] ack;
    logic [30:0] now;
  } item_t;

endpackage

// File: rtl/bdws_if.sv
`timescale 1ns / 1ps

interface bdws_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [30:0]        file_size;
  logic               is_archive;
  logic signed [12:0] block_len;
  logic [15:0]        ack_block;
  logic [30:0]        now_ms;

  modport source (output valid, cmd, file_size, is_archive, block_len, ack_block, now_ms,
                  input ready);
  modport sink (input valid, cmd, file_size, is_archive, block_len, ack_block, now_ms,
                output ready);
endinterface

interface bdws_out_if #(
  parameter int SLOT_W = 3
);
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        block_number;
  logic [SLOT_W-1:0]  slot;
  logic [11:0]        block_size;
  logic               carries_file_size;
  logic signed [31:0] file_size_out;
  logic [1:0]         error_code;

  modport source (output valid, kind, block_number, slot, block_size, carries_file_size,
                  file_size_out, error_code, input ready);
  modport sink (input valid, kind, block_number, slot, block_size, carries_file_size,
                file_size_out, error_code, output ready);
endinterface

// File: rtl/bdws_front.sv
`timescale 1ns / 1ps

module bdws_front
  import bdws_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  bdws_in_if.sink      in_i,
  input  logic         pop_i,
  output item_t        item_o,
  output logic         item_vld_o
);

  item_t       entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  item_t       cls;
  logic        push;
  logic        pop;

  // Refuse starts up front; configuration must not change while busy (unchecked).
  always_comb begin
    cls           = '0;
    cls.cmd       = cmd_e'(in_i.cmd);
    cls.file_size = in_i.file_size;
    cls.ack       = in_i.ack_block;
    cls.now       = in_i.now_ms;
    cls.len_neg   = in_i.block_len[12];
    cls.refused   = 1'b1;
    if (in_i.is_archive) begin
      cls.err = ErrArchive;
    end else if (!cfg_i.download_enabled) begin
      cls.err = cfg_i.pure_mode ? ErrDisabledPure : ErrDisabled;
    end else if (in_i.file_size == 31'd0) begin
      cls.err = ErrNotFound;
    end else begin
      cls.err     = ErrArchive;
      cls.refused = 1'b0;
    end
    if (in_i.block_len[11:0] > BlockBytes) begin
      cls.len = BlockBytes;
    end else begin
      cls.len = in_i.block_len[11:0];
    end
  end

  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (count_q != 2'd0);
  assign item_vld_o = (count_q != 2'd0);
  assign item_o     = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// File: rtl/bdws_back.sv
`timescale 1ns / 1ps

module bdws_back
  import bdws_pkg::*;
#(
  parameter int WINDOW_BLOCKS = WindowBlocksDef,
  parameter int SLOT_W = $clog2(WINDOW_BLOCKS)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  item_t        item_i,
  input  logic         item_vld_i,
  output logic         pop_o,
  bdws_out_if.source   out_o
);

  localparam logic [16:0] WinDepth = 17'(WINDOW_BLOCKS);

  logic        active_q, active_d;
  logic [30:0] total_q, total_d;
  logic [30:0] bytes_q, bytes_d;
  logic [15:0] fill_q, fill_d;
  logic [15:0] acked_q, acked_d;
  logic [15:0] send_q, send_d;
  logic        end_q, end_d;
  logic [30:0] last_q, last_d;
  logic        pend_q, pend_d;

  logic [11:0] slot_mem [WINDOW_BLOCKS];
  logic [11:0] size_rd_q;

  logic              out_vld_q;
  kind_e             kind_q;
  logic [15:0]       blk_q;
  logic [SLOT_W-1:0] slot_q;
  logic              size_zero_q;
  logic              carries_q;
  logic [31:0]       fs_q;
  err_e              err_q;

  logic              go;
  logic              emit;
  kind_e             e_kind;
  logic [15:0]       e_blk;
  logic [SLOT_W-1:0] e_slot;
  logic              e_size_zero;
  logic              e_carries;
  logic [31:0]       e_fs;
  err_e              e_err;
  logic              mem_we;
  logic [SLOT_W-1:0] rd_idx;

  logic        do_refill;
  logic [15:0] rf_fill;
  logic [15:0] rf_acked;
  logic        rf_eq;
  logic [15:0] rf_span;
  logic [15:0] span;
  logic [15:0] nspan;
  logic [30:0] remain;
  logic [30:0] diff;
  logic [15:0] sb;
  logic        fire;

  assign go    = pop_o;
  assign pop_o = item_vld_i && (!out_vld_q || out_o.ready);

  // Slot index is the low bits of the block number; the window depth must be a power of two, which is not checked here.
  always_comb begin
    active_d    = active_q;
    total_d     = total_q;
    bytes_d     = bytes_q;
    fill_d      = fill_q;
    acked_d     = acked_q;
    send_d      = send_q;
    end_d       = end_q;
    last_d      = last_q;
    pend_d      = pend_q;
    emit        = 1'b0;
    e_kind      = KindRead;
    e_blk       = 16'd0;
    e_slot      = '0;
    e_size_zero = 1'b1;
    e_carries   = 1'b0;
    e_fs        = 32'd0;
    e_err       = ErrArchive;
    mem_we      = 1'b0;
    rd_idx      = send_q[SLOT_W-1:0];
    do_refill   = 1'b0;
    rf_fill     = fill_q;
    rf_acked    = acked_q;
    rf_eq       = (bytes_q == total_q);
    span        = fill_q - acked_q;
    nspan       = fill_q - item_i.ack;
    remain      = total_q - bytes_q;
    diff        = item_i.now - last_q;
    sb          = send_q;
    fire        = 1'b0;

    case (item_i.cmd)
      CmdStart: begin
        pend_d = item_i.refused ? 1'b0 : 1'b1;
        if (item_i.refused) begin
          active_d  = 1'b0;
          emit      = 1'b1;
          e_kind    = KindError;
          e_carries = 1'b1;
          e_fs      = 32'hFFFF_FFFF;
          e_err     = item_i.err;
        end else begin
          // A fresh download always opens with a read into slot zero.
          active_d = 1'b1;
          total_d  = item_i.file_size;
          bytes_d  = 31'd0;
          fill_d   = 16'd0;
          acked_d  = 16'd0;
          send_d   = 16'd0;
          end_d    = 1'b0;
          emit     = 1'b1;
          e_kind   = KindRead;
        end
      end
      CmdRead: begin
        if (active_q && pend_q) begin
          pend_d    = 1'b0;
          do_refill = 1'b1;
          if (item_i.len_neg) begin
            bytes_d = total_q;
            rf_eq   = 1'b1;
          end else begin
            mem_we  = 1'b1;
            rf_fill = fill_q + 16'd1;
            fill_d  = rf_fill;
            if ({19'd0, item_i.len} >= remain) begin
              bytes_d = total_q;
              rf_eq   = 1'b1;
            end else begin
              bytes_d = bytes_q + {19'd0, item_i.len};
              rf_eq   = 1'b0;
            end
          end
        end
      end
      CmdAck: begin
        if (active_q && ((item_i.ack - acked_q) <= span)) begin
          acked_d  = item_i.ack;
          rf_acked = item_i.ack;
          if ((send_q - item_i.ack) > nspan) begin
            send_d = item_i.ack;
          end
          do_refill = !pend_q;
        end
      end
      CmdSend: begin
        if (active_q && (acked_q != fill_q)) begin
          fire = 1'b1;
          if (send_q == fill_q) begin
            if (diff[30]) begin
              fire = 1'b0;
            end else if (diff > {15'd0, cfg_i.timeout}) begin
              sb = acked_q;
            end else begin
              fire = 1'b0;
            end
          end
          if (fire) begin
            emit        = 1'b1;
            e_kind      = KindBlock;
            e_blk       = sb;
            e_slot      = sb[SLOT_W-1:0];
            rd_idx      = sb[SLOT_W-1:0];
            // The end marker is always the newest block once it has been queued.
            e_size_zero = end_q && ((sb + 16'd1) == fill_q);
            e_carries   = (sb == 16'd0);
            e_fs        = (sb == 16'd0) ? {1'b0, total_q} : 32'd0;
            send_d      = sb + 16'd1;
            last_d      = item_i.now;
          end
        end
      end
      default: begin
      end
    endcase

    rf_span = rf_fill - rf_acked;
    if (do_refill && ({1'b0, rf_span} < WinDepth)) begin
      if (!rf_eq) begin
        pend_d = 1'b1;
        emit   = 1'b1;
        e_kind = KindRead;
        e_slot = rf_fill[SLOT_W-1:0];
      end else if (!end_q) begin
        fill_d = rf_fill + 16'd1;
        end_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      total_q   <= 31'd0;
      bytes_q   <= 31'd0;
      fill_q    <= 16'd0;
      acked_q   <= 16'd0;
      send_q    <= 16'd0;
      end_q     <= 1'b0;
      last_q    <= 31'd0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (go) begin
        active_q <= active_d;
        total_q  <= total_d;
        bytes_q  <= bytes_d;
        fill_q   <= fill_d;
        acked_q  <= acked_d;
        send_q   <= send_d;
        end_q    <= end_d;
        last_q   <= last_d;
        pend_q   <= pend_d;
      end
      if (go && emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      kind_q      <= e_kind;
      blk_q       <= e_blk;
      slot_q      <= e_slot;
      size_zero_q <= e_size_zero;
      carries_q   <= e_carries;
      fs_q        <= e_fs;
      err_q       <= e_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && mem_we) begin
      slot_mem[fill_q[SLOT_W-1:0]] <= item_i.len;
    end
    if (go && emit) begin
      size_rd_q <= slot_mem[rd_idx];
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.kind              = kind_q;
  assign out_o.block_number      = blk_q;
  assign out_o.slot              = slot_q;
  assign out_o.block_size        = size_zero_q ? 12'd0 : size_rd_q;
  assign out_o.carries_file_size = carries_q;
  assign out_o.file_size_out     = fs_q;
  assign out_o.error_code        = err_q;

endmodule

// File: rtl/block_download_window_sender.sv
`timescale 1ns / 1ps
// Requests are registered in the front queue, results in the back output register.
// Throughput: one request per cycle while out_o.ready is high; the back stage takes one
// queued request a cycle; the output register lets it run on while the previous result is taken.
// Reset: rst_ni clears all counters, the queue and the output valid asynchronously.
// The slot length store is not cleared; WINDOW_BLOCKS must be a power of two.

module block_download_window_sender
  import bdws_pkg::*;
#(
  parameter int WINDOW_BLOCKS = WindowBlocksDef,
  parameter int SLOT_W = $clog2(WINDOW_BLOCKS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  bdws_in_if.sink             in_i,
  bdws_out_if.source          out_o
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_vld;
  logic  pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.download_enabled <= 1'b0;
      cfg_q.pure_mode        <= 1'b0;
      cfg_q.timeout          <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDownloadEnabled: cfg_q.download_enabled <= cfg_data_i[0];
        CfgPureMode:        cfg_q.pure_mode        <= cfg_data_i[0];
        CfgTimeout:         cfg_q.timeout          <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  bdws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_i       (in_i),
    .pop_i      (pop),
    .item_o     (item),
    .item_vld_o (item_vld)
  );

  bdws_back #(
    .WINDOW_BLOCKS (WINDOW_BLOCKS),
    .SLOT_W        (SLOT_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_i     (item),
    .item_vld_i (item_vld),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
